[hw/rtl/ted_pkg.sv]
package ted_pkg;

    localparam int MAX_EDGES  = 1024;
    localparam int INDEX_BITS = 16;
    localparam int ADDR_W     = $clog2(MAX_EDGES);
    localparam int CNT_W      = $clog2(MAX_EDGES + 1);
    localparam int POS_W      = 10;
    localparam int EDGES_PER_TRI = 3;
    localparam int SLOT_W     = $clog2(EDGES_PER_TRI + 1);

    typedef logic [INDEX_BITS-1:0] vidx_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic advance;
        logic record;
        logic push;
    } ted_cmd_t;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic             last_edge;
        logic             have_result;
        logic             last_push;
        logic             out_free;
        logic [CNT_W-1:0] total;
    } ted_status_t;

    typedef struct packed {
        vidx_t            edge_low;
        vidx_t            edge_high;
        logic [POS_W-1:0] edge_position;
        logic             dropped;
    } ted_result_t;

endpackage

[hw/rtl/ted_tri_if.sv]
interface ted_tri_if;
    logic              valid;
    logic              ready;
    logic              start_of_mesh;
    ted_pkg::vidx_t    corner_a;
    ted_pkg::vidx_t    corner_b;
    ted_pkg::vidx_t    corner_c;

    modport source (output valid, output start_of_mesh, output corner_a,
                    output corner_b, output corner_c, input ready);
    modport sink   (input valid, input start_of_mesh, input corner_a,
                    input corner_b, input corner_c, output ready);
endinterface

[hw/rtl/ted_edge_if.sv]
interface ted_edge_if;
    logic                          valid;
    logic                          ready;
    ted_pkg::vidx_t                edge_low;
    ted_pkg::vidx_t                edge_high;
    logic [ted_pkg::POS_W-1:0]     edge_position;
    logic                          dropped;
    logic                          last;

    modport source (output valid, output edge_low, output edge_high,
                    output edge_position, output dropped, output last, input ready);
    modport sink   (input valid, input edge_low, input edge_high,
                    input edge_position, input dropped, input last, output ready);
endinterface

[hw/rtl/ted_ctrl.sv]
module ted_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ted_pkg::ted_status_t status,
    output ted_pkg::ted_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || status.miss)
                begin
                    cmd.advance = 1'b1;
                    cmd.record  = status.miss;
                    if (status.last_edge)
                    begin
                        state_next = (status.miss || status.have_result) ? S_EMIT : S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    if (status.last_push)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/ted_datapath.sv]
module ted_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ted_pkg::ted_cmd_t    cmd,
    output ted_pkg::ted_status_t status,
    input  logic                 start_of_mesh,
    input  ted_pkg::vidx_t       corner_a,
    input  ted_pkg::vidx_t       corner_b,
    input  ted_pkg::vidx_t       corner_c,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ted_pkg::ted_result_t out_data,
    output logic                 out_last
);

    localparam int KEY_W = 2 * ted_pkg::INDEX_BITS;

    logic [KEY_W-1:0] edge_mem [ted_pkg::MAX_EDGES];
    logic [KEY_W-1:0] mem_q_reg;

    ted_pkg::vidx_t a_reg, b_reg, c_reg;
    logic [1:0]                   edge_sel_reg;
    logic [ted_pkg::CNT_W-1:0]    total_reg;
    logic [ted_pkg::CNT_W-1:0]    rd_idx_reg;
    logic                         cmp_valid_reg;
    logic [ted_pkg::SLOT_W-1:0]   res_cnt_reg;
    logic [ted_pkg::SLOT_W-1:0]   emit_idx_reg;
    ted_pkg::ted_result_t         slot_reg [ted_pkg::EDGES_PER_TRI];
    logic                         out_valid_reg;
    ted_pkg::ted_result_t         out_data_reg;
    logic                         out_last_reg;

    ted_pkg::vidx_t   p, q, lo, hi;
    logic [KEY_W-1:0] key;
    logic             issue;
    logic             full;
    ted_pkg::ted_result_t new_res;

    always_comb
    begin
        case (edge_sel_reg)
            2'd0:
            begin
                p = c_reg;
                q = a_reg;
            end
            2'd1:
            begin
                p = a_reg;
                q = b_reg;
            end
            default:
            begin
                p = b_reg;
                q = c_reg;
            end
        endcase
        lo  = (p < q) ? p : q;
        hi  = (p < q) ? q : p;
        key = {hi, lo};
    end

    assign full  = (total_reg == ted_pkg::CNT_W'(ted_pkg::MAX_EDGES));
    assign issue = cmd.scan && !cmd.advance && (rd_idx_reg < total_reg);

    always_comb
    begin
        new_res.edge_low      = lo;
        new_res.edge_high     = hi;
        new_res.edge_position = full ? '0 : ted_pkg::POS_W'(total_reg);
        new_res.dropped       = full;
    end

    assign status.hit         = cmd.scan && cmp_valid_reg && (mem_q_reg == key);
    assign status.miss        = cmd.scan && !cmp_valid_reg && (rd_idx_reg >= total_reg);
    assign status.last_edge   = (edge_sel_reg == 2'd2);
    assign status.have_result = (res_cnt_reg != '0);
    assign status.last_push   = (emit_idx_reg == res_cnt_reg - 1'b1);
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.total       = total_reg;

    // edge table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.record && !full)
        begin
            edge_mem[total_reg[ted_pkg::ADDR_W-1:0]] <= key;
        end
        mem_q_reg <= edge_mem[rd_idx_reg[ted_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= corner_a;
            b_reg <= corner_b;
            c_reg <= corner_c;
        end
        if (cmd.record)
        begin
            slot_reg[res_cnt_reg[1:0]] <= new_res;
        end
        if (cmd.push)
        begin
            out_data_reg <= slot_reg[emit_idx_reg[1:0]];
            out_last_reg <= status.last_push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_sel_reg  <= '0;
            total_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            res_cnt_reg   <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                edge_sel_reg  <= '0;
                rd_idx_reg    <= '0;
                cmp_valid_reg <= 1'b0;
                res_cnt_reg   <= '0;
                emit_idx_reg  <= '0;
                if (start_of_mesh)
                begin
                    total_reg <= '0;
                end
            end
            else if (cmd.advance)
            begin
                edge_sel_reg  <= edge_sel_reg + 2'd1;
                rd_idx_reg    <= '0;
                cmp_valid_reg <= 1'b0;
                if (cmd.record)
                begin
                    res_cnt_reg <= res_cnt_reg + 1'b1;
                    if (!full)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                end
            end
            else if (cmd.scan)
            begin
                cmp_valid_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
            if (cmd.push)
            begin
                emit_idx_reg  <= emit_idx_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

[hw/rtl/triangle_edge_dedup.sv]
// Unique edge extraction from a triangle list.
// triangles (sink): one triangle per item, corners a, b, c and start_of_mesh,
//   which empties the edge table before that triangle.
// edges (source): one item per newly found edge, (low, high) with its list
//   position; dropped marks an edge that found the table full; last marks the
//   final item caused by a triangle. A triangle whose edges are all known
//   gives no item.
// Timing: edges are handled in the order (c,a), (a,b), (b,c). Each edge scans
//   the table one entry per cycle through the registered read port of the
//   edge memory, over the stored edges, and stops early on a match. The
//   results of a triangle are then emitted in turn.
// Results wait in an output register; the next triangle is taken while the
//   final result of the previous one still waits. A stalled receiver holds the
//   block in its emit phase until each result is taken.
// Reset empties the edge table and the output register; no clearing pass.
module triangle_edge_dedup (
    input  logic        clk,
    input  logic        rst_n,
    ted_tri_if.sink     triangles,
    ted_edge_if.source  edges
);

    ted_pkg::ted_cmd_t    cmd;
    ted_pkg::ted_status_t status;
    ted_pkg::ted_result_t out_data;

    ted_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (triangles.valid),
        .in_ready (triangles.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ted_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .start_of_mesh (triangles.start_of_mesh),
        .corner_a      (triangles.corner_a),
        .corner_b      (triangles.corner_b),
        .corner_c      (triangles.corner_c),
        .out_valid     (edges.valid),
        .out_ready     (edges.ready),
        .out_data      (out_data),
        .out_last      (edges.last)
    );

    assign edges.edge_low      = out_data.edge_low;
    assign edges.edge_high     = out_data.edge_high;
    assign edges.edge_position = out_data.edge_position;
    assign edges.dropped       = out_data.dropped;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.total <= ted_pkg::CNT_W'(ted_pkg::MAX_EDGES))
        else $error("edge count beyond table depth");

    a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.hit && status.miss))
        else $error("edge both found and missed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (triangles.valid && triangles.ready) |=> !triangles.ready)
        else $error("triangle taken while busy");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!edges.valid || edges.ready))
        else $error("result overwritten");

endmodule
